>>> hdl/rat_pkg.sv
// Shared types and codes for the rational accumulator ALU.
// Used by rat_ctrl, rat_dp and the top level; no dependencies of its own.
`timescale 1ns / 1ps

package rat_pkg;

	// command codes
	localparam logic [2:0] CMD_LOAD = 3'd0;
	localparam logic [2:0] CMD_ADD  = 3'd1;
	localparam logic [2:0] CMD_SUB  = 3'd2;
	localparam logic [2:0] CMD_MUL  = 3'd3;
	localparam logic [2:0] CMD_DIV  = 3'd4;

	// status codes
	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_ZERO = 2'd1;
	localparam logic [1:0] ST_OVF  = 2'd2;

	typedef struct packed {
		logic [2:0]         command;
		logic signed [31:0] operand_numerator;
		logic signed [31:0] operand_denominator;
	} in_t;

	typedef struct packed {
		logic signed [31:0] result_numerator;
		logic [30:0]        result_denominator;
		logic [1:0]         status;
	} out_t;

	// datapath operations
	typedef enum logic [3:0] {
		OP_NONE,
		OP_INIT,   // capture operand and accumulator
		OP_SETST,  // load status code
		OP_LOAD,   // num/den from reduced operand
		OP_GCD,    // gcd(x, y) -> dst
		OP_DIV,    // x / y -> dst (narrow dividend)
		OP_MOD,    // num % y -> dst
		OP_DIVW,   // num / y -> dst
		OP_MUL,    // x * y -> dst
		OP_COMB,   // signed combine of p and q -> num
		OP_FIN,    // range check and commit
		OP_EMIT    // load output register
	} op_t;

	// datapath register names
	typedef enum logic [3:0] {
		R_A, R_B, R_C, R_D, R_G, R_G1, R_G2, R_BG,
		R_DG, R_X, R_Y, R_R, R_P, R_Q, R_NUM, R_DEN
	} reg_t;

	typedef struct packed {
		logic       start;
		op_t        op;
		reg_t       src_x;
		reg_t       src_y;
		reg_t       dst;
		logic [1:0] code;
		logic       sr_xor;
	} dp_cmd_t;

	typedef struct packed {
		logic       done;
		logic       out_free;
		logic [2:0] cmd;
		logic       rd_zero;
		logic       c_zero;
		logic       num_zero;
	} dp_stat_t;

	typedef enum logic [4:0] {
		S_IDLE, S_CHK, S_RG, S_RC, S_RD, S_OPSEL, S_LD,
		S_AG, S_ABG, S_ADG, S_AP, S_AQ, S_AC, S_AZ, S_AR, S_AG2, S_AN, S_AD, S_ADEN,
		S_MG1, S_MG2, S_MX, S_MY, S_MN, S_MX2, S_MY2, S_MD,
		S_FIN, S_EMIT
	} state_t;

endpackage

>>> hdl/rat_gcd.sv
// Binary (shift and subtract) GCD unit, one step per cycle.
// Standalone; no package dependency.
`timescale 1ns / 1ps

module rat_gcd #(
	parameter int MW = 32
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [MW-1:0] x,
	input  logic [MW-1:0] y,
	output logic          done,
	output logic [MW-1:0] res
);
	localparam int KW = $clog2(MW + 1);

	logic          busy_q;
	logic          done_q;
	logic [MW-1:0] u_q;
	logic [MW-1:0] v_q;
	logic [KW-1:0] k_q;
	logic [MW-1:0] res_q;
	logic          fin;

	assign fin = (u_q == '0) || (v_q == '0);

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				if (x == '0 && y == '0) begin
					done_q <= 1'b1;
				end else begin
					busy_q <= 1'b1;
				end
			end else if (busy_q && fin) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	// Stein steps; gcd(0,0) reads as 1
	always_ff @(posedge clk) begin
		if (start) begin
			u_q   <= x;
			v_q   <= y;
			k_q   <= '0;
			res_q <= MW'(1);
		end else if (busy_q) begin
			if (u_q == '0) begin
				res_q <= v_q << k_q;
			end else if (v_q == '0) begin
				res_q <= u_q << k_q;
			end else if (!u_q[0] && !v_q[0]) begin
				u_q <= u_q >> 1;
				v_q <= v_q >> 1;
				k_q <= k_q + 1'b1;
			end else if (!u_q[0]) begin
				u_q <= u_q >> 1;
			end else if (!v_q[0]) begin
				v_q <= v_q >> 1;
			end else if (u_q >= v_q) begin
				u_q <= u_q - v_q;
			end else begin
				v_q <= v_q - u_q;
			end
		end
	end

	assign done = done_q;
	assign res  = res_q;

endmodule

>>> hdl/rat_div.sv
// Restoring divider, one quotient bit per cycle, double-width dividend.
// Standalone; no package dependency.
`timescale 1ns / 1ps

module rat_div #(
	parameter int MW = 32
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  logic            wide,
	input  logic [2*MW-1:0] dividend,
	input  logic [MW-1:0]   divisor,
	output logic            done,
	output logic [2*MW-1:0] quo,
	output logic [MW-1:0]   rem
);
	localparam int DW = 2 * MW;
	localparam int CW = $clog2(DW + 1);

	logic          busy_q;
	logic          done_q;
	logic [DW-1:0] n_q;
	logic [MW-1:0] r_q;
	logic [MW-1:0] d_q;
	logic [CW-1:0] cnt_q;
	logic [MW:0]   trial;
	logic [MW:0]   diff;
	logic          ge;

	assign trial = {r_q, n_q[DW-1]};
	assign ge    = trial >= {1'b0, d_q};
	assign diff  = trial - {1'b0, d_q};

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
			end else if (busy_q && cnt_q == CW'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	// narrow dividend sits in the top half and runs half the steps
	always_ff @(posedge clk) begin
		if (start) begin
			n_q   <= wide ? dividend : {dividend[MW-1:0], {MW{1'b0}}};
			r_q   <= '0;
			d_q   <= divisor;
			cnt_q <= wide ? CW'(DW) : CW'(MW);
		end else if (busy_q) begin
			r_q   <= ge ? diff[MW-1:0] : trial[MW-1:0];
			n_q   <= {n_q[DW-2:0], ge};
			cnt_q <= cnt_q - 1'b1;
		end
	end

	assign done = done_q;
	assign quo  = n_q;
	assign rem  = r_q;

endmodule

>>> hdl/rat_mul.sv
// Shift-add multiplier, one multiplier bit per cycle, stops early on zero.
// Standalone; no package dependency.
`timescale 1ns / 1ps

module rat_mul #(
	parameter int MW = 32
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  logic [MW-1:0]   x,
	input  logic [MW-1:0]   y,
	output logic            done,
	output logic [2*MW-1:0] prod
);
	localparam int DW = 2 * MW;

	logic          busy_q;
	logic          done_q;
	logic [DW-1:0] acc_q;
	logic [DW-1:0] mc_q;
	logic [MW-1:0] mp_q;

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
			end else if (busy_q && mp_q == '0) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	// add shifted multiplicand per set bit
	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= '0;
			mc_q  <= DW'(x);
			mp_q  <= y;
		end else if (busy_q && mp_q != '0) begin
			if (mp_q[0]) begin
				acc_q <= acc_q + mc_q;
			end
			mc_q <= mc_q << 1;
			mp_q <= mp_q >> 1;
		end
	end

	assign done = done_q;
	assign prod = acc_q;

endmodule

>>> hdl/rat_dp.sv
// Datapath: working registers, shared GCD/divide/multiply units, accumulator
// and output register. Depends on rat_pkg, rat_gcd, rat_div, rat_mul.
`timescale 1ns / 1ps

module rat_dp #(
	parameter int WIDTH = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  rat_pkg::in_t      in_data,
	input  rat_pkg::dp_cmd_t  cmd,
	output rat_pkg::dp_stat_t stat,
	output logic              out_valid,
	input  logic              out_ready,
	output rat_pkg::out_t     out_data
);
	localparam int MW = (WIDTH > 32) ? WIDTH : 32;
	localparam int DW = 2 * MW;
	localparam logic [DW-1:0] NEG_LIM = {{(DW-1){1'b0}}, 1'b1} << (WIDTH - 1);
	localparam logic [DW-1:0] POS_LIM = NEG_LIM - 1'b1;

	// working registers
	logic [MW-1:0] a_q, b_q, c_q, d_q, g_q, g1_q, g2_q, bg_q, dg_q, x_q, y_q, r_q;
	logic [DW-1:0] p_q, q_q, num_q, den_q;
	logic          sa_q, sc_q, sr_q;
	logic [2:0]    cmd_q;
	logic          rd_zero_q, c_zero_q;
	rat_pkg::reg_t dst_q;
	rat_pkg::op_t  pop_q;
	logic          sr_xor_q;

	// accumulator, status, output
	logic signed [WIDTH-1:0] acc_num_q;
	logic [WIDTH-2:0]        acc_den_q;
	logic [1:0]              st_q;
	logic                    out_valid_q;
	rat_pkg::out_t           out_q;

	logic          go;
	logic [MW-1:0] x_sel, y_sel;
	logic          gcd_go, div_go, mul_go, div_wide;
	logic          gcd_done, div_done, mul_done, res_wr;
	logic [MW-1:0] gcd_res, div_rem;
	logic [DW-1:0] div_quo, mul_prod, div_dvd, res_val;

	// operand and accumulator capture
	logic [31:0]           rn, rdn, cmag, dmag;
	logic                  c0, sc_init;
	logic signed [MW-1:0]  acc_ext;
	logic [MW-1:0]         amag;

	// final check
	logic          nz, sr_f, ovf;
	logic [DW-1:0] den_f, nlim;

	assign go = cmd.start;

	// operand sign and magnitude
	always_comb begin
		rn      = in_data.operand_numerator;
		rdn     = in_data.operand_denominator;
		cmag    = rn[31] ? (~rn + 32'd1) : rn;
		dmag    = rdn[31] ? (~rdn + 32'd1) : rdn;
		c0      = (cmag == '0);
		sc_init = (c0 ? 1'b0 : (rn[31] ^ rdn[31])) ^ (in_data.command == rat_pkg::CMD_SUB);
		acc_ext = MW'(acc_num_q);
		amag    = acc_num_q[WIDTH-1] ? (~acc_ext + 1'b1) : acc_ext;
	end

	// source selection
	always_comb begin
		case (cmd.src_x)
			rat_pkg::R_A:  x_sel = a_q;
			rat_pkg::R_B:  x_sel = b_q;
			rat_pkg::R_C:  x_sel = c_q;
			rat_pkg::R_D:  x_sel = d_q;
			rat_pkg::R_G:  x_sel = g_q;
			rat_pkg::R_G1: x_sel = g1_q;
			rat_pkg::R_G2: x_sel = g2_q;
			rat_pkg::R_BG: x_sel = bg_q;
			rat_pkg::R_DG: x_sel = dg_q;
			rat_pkg::R_X:  x_sel = x_q;
			rat_pkg::R_Y:  x_sel = y_q;
			rat_pkg::R_R:  x_sel = r_q;
			default:       x_sel = '0;
		endcase
		case (cmd.src_y)
			rat_pkg::R_A:  y_sel = a_q;
			rat_pkg::R_B:  y_sel = b_q;
			rat_pkg::R_C:  y_sel = c_q;
			rat_pkg::R_D:  y_sel = d_q;
			rat_pkg::R_G:  y_sel = g_q;
			rat_pkg::R_G1: y_sel = g1_q;
			rat_pkg::R_G2: y_sel = g2_q;
			rat_pkg::R_BG: y_sel = bg_q;
			rat_pkg::R_DG: y_sel = dg_q;
			rat_pkg::R_X:  y_sel = x_q;
			rat_pkg::R_Y:  y_sel = y_q;
			rat_pkg::R_R:  y_sel = r_q;
			default:       y_sel = '0;
		endcase
	end

	// unit launch
	assign gcd_go   = go && cmd.op == rat_pkg::OP_GCD;
	assign mul_go   = go && cmd.op == rat_pkg::OP_MUL;
	assign div_go   = go && (cmd.op == rat_pkg::OP_DIV || cmd.op == rat_pkg::OP_DIVW
		|| cmd.op == rat_pkg::OP_MOD);
	assign div_wide = cmd.op != rat_pkg::OP_DIV;
	assign div_dvd  = div_wide ? num_q : DW'(x_sel);

	rat_gcd #(.MW(MW)) u_gcd (
		.clk(clk), .arst_n(arst_n), .start(gcd_go), .x(x_sel), .y(y_sel),
		.done(gcd_done), .res(gcd_res)
	);

	rat_div #(.MW(MW)) u_div (
		.clk(clk), .arst_n(arst_n), .start(div_go), .wide(div_wide),
		.dividend(div_dvd), .divisor(y_sel), .done(div_done), .quo(div_quo), .rem(div_rem)
	);

	rat_mul #(.MW(MW)) u_mul (
		.clk(clk), .arst_n(arst_n), .start(mul_go), .x(x_sel), .y(y_sel),
		.done(mul_done), .prod(mul_prod)
	);

	// unit result writeback
	assign res_wr = gcd_done || div_done || mul_done;
	always_comb begin
		case (pop_q)
			rat_pkg::OP_GCD:  res_val = DW'(gcd_res);
			rat_pkg::OP_MOD:  res_val = DW'(div_rem);
			rat_pkg::OP_DIV:  res_val = div_quo;
			rat_pkg::OP_DIVW: res_val = div_quo;
			rat_pkg::OP_MUL:  res_val = mul_prod;
			default:          res_val = '0;
		endcase
	end

	// final range check; zero becomes 0/1
	always_comb begin
		nz    = (num_q == '0);
		sr_f  = nz ? 1'b0 : sr_q;
		den_f = nz ? DW'(1) : den_q;
		nlim  = sr_f ? NEG_LIM : POS_LIM;
		ovf   = (num_q > nlim) || (den_f > POS_LIM) || (den_f == '0);
	end

	// accumulator, status and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_num_q   <= '0;
			acc_den_q   <= (WIDTH-1)'(1);
			st_q        <= rat_pkg::ST_OK;
			out_valid_q <= 1'b0;
		end else begin
			if (go && cmd.op == rat_pkg::OP_SETST) begin
				st_q <= cmd.code;
			end
			if (go && cmd.op == rat_pkg::OP_FIN) begin
				if (ovf) begin
					st_q <= rat_pkg::ST_OVF;
				end else begin
					st_q      <= rat_pkg::ST_OK;
					acc_num_q <= sr_f ? (~num_q[WIDTH-1:0] + 1'b1) : num_q[WIDTH-1:0];
					acc_den_q <= den_f[WIDTH-2:0];
				end
			end
			if (go && cmd.op == rat_pkg::OP_EMIT) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		if (go && cmd.op == rat_pkg::OP_INIT) begin
			cmd_q     <= in_data.command;
			rd_zero_q <= (rdn == '0);
			c_zero_q  <= c0;
			c_q       <= MW'(cmag);
			d_q       <= c0 ? MW'(1) : MW'(dmag);
			sc_q      <= sc_init;
			sa_q      <= acc_num_q[WIDTH-1];
			a_q       <= amag;
			b_q       <= MW'(acc_den_q);
		end
		if (go && (gcd_go || div_go || mul_go)) begin
			dst_q    <= cmd.dst;
			pop_q    <= cmd.op;
			sr_xor_q <= cmd.sr_xor;
		end
		if (go && cmd.op == rat_pkg::OP_LOAD) begin
			num_q <= DW'(c_q);
			den_q <= DW'(d_q);
			sr_q  <= sc_q;
		end
		// add/subtract on magnitudes
		if (go && cmd.op == rat_pkg::OP_COMB) begin
			if (sa_q == sc_q) begin
				num_q <= p_q + q_q;
				sr_q  <= sa_q;
			end else if (p_q >= q_q) begin
				num_q <= p_q - q_q;
				sr_q  <= sa_q;
			end else begin
				num_q <= q_q - p_q;
				sr_q  <= sc_q;
			end
		end
		if (res_wr) begin
			if (sr_xor_q) begin
				sr_q <= sa_q ^ sc_q;
			end
			case (dst_q)
				rat_pkg::R_A:   a_q   <= res_val[MW-1:0];
				rat_pkg::R_B:   b_q   <= res_val[MW-1:0];
				rat_pkg::R_C:   c_q   <= res_val[MW-1:0];
				rat_pkg::R_D:   d_q   <= res_val[MW-1:0];
				rat_pkg::R_G:   g_q   <= res_val[MW-1:0];
				rat_pkg::R_G1:  g1_q  <= res_val[MW-1:0];
				rat_pkg::R_G2:  g2_q  <= res_val[MW-1:0];
				rat_pkg::R_BG:  bg_q  <= res_val[MW-1:0];
				rat_pkg::R_DG:  dg_q  <= res_val[MW-1:0];
				rat_pkg::R_X:   x_q   <= res_val[MW-1:0];
				rat_pkg::R_Y:   y_q   <= res_val[MW-1:0];
				rat_pkg::R_R:   r_q   <= res_val[MW-1:0];
				rat_pkg::R_P:   p_q   <= res_val;
				rat_pkg::R_Q:   q_q   <= res_val;
				rat_pkg::R_NUM: num_q <= res_val;
				rat_pkg::R_DEN: den_q <= res_val;
				default: ;
			endcase
		end
		if (go && cmd.op == rat_pkg::OP_EMIT) begin
			out_q.result_numerator   <= 32'(acc_num_q);
			out_q.result_denominator <= 31'(acc_den_q);
			out_q.status             <= st_q;
		end
	end

	// status to controller
	assign stat.done     = res_wr;
	assign stat.out_free = !out_valid_q || out_ready;
	assign stat.cmd      = cmd_q;
	assign stat.rd_zero  = rd_zero_q;
	assign stat.c_zero   = c_zero_q;
	assign stat.num_zero = (num_q == '0);

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

>>> hdl/rat_ctrl.sv
// Controller: sequences reduction and command steps on the datapath units.
// Depends on rat_pkg.
`timescale 1ns / 1ps

module rat_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  rat_pkg::dp_stat_t stat,
	output rat_pkg::dp_cmd_t  cmd
);
	rat_pkg::state_t state_q, state_d, after;
	logic            issued_q, issued_d, multi;
	rat_pkg::reg_t   u_reg, v_reg;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= rat_pkg::S_IDLE;
			issued_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			issued_q <= issued_d;
		end
	end

	// multiply pairs a with d, divide pairs a with c
	assign u_reg = (stat.cmd == rat_pkg::CMD_MUL) ? rat_pkg::R_D : rat_pkg::R_C;
	assign v_reg = (stat.cmd == rat_pkg::CMD_MUL) ? rat_pkg::R_C : rat_pkg::R_D;

	// next state and commands
	always_comb begin
		state_d    = state_q;
		issued_d   = issued_q;
		after      = state_q;
		multi      = 1'b0;
		in_ready   = 1'b0;
		cmd.start  = 1'b0;
		cmd.op     = rat_pkg::OP_NONE;
		cmd.src_x  = rat_pkg::R_A;
		cmd.src_y  = rat_pkg::R_A;
		cmd.dst    = rat_pkg::R_A;
		cmd.code   = rat_pkg::ST_OK;
		cmd.sr_xor = 1'b0;
		case (state_q)
			rat_pkg::S_IDLE: begin
				in_ready  = 1'b1;
				cmd.op    = rat_pkg::OP_INIT;
				cmd.start = in_valid;
				if (in_valid) begin
					state_d = rat_pkg::S_CHK;
				end
			end
			rat_pkg::S_CHK: begin
				if (!(stat.cmd inside {rat_pkg::CMD_LOAD, rat_pkg::CMD_ADD, rat_pkg::CMD_SUB,
					rat_pkg::CMD_MUL, rat_pkg::CMD_DIV})) begin
					cmd.start = 1'b1;
					cmd.op    = rat_pkg::OP_SETST;
					cmd.code  = rat_pkg::ST_OK;
					state_d   = rat_pkg::S_EMIT;
				end else if (stat.rd_zero) begin
					cmd.start = 1'b1;
					cmd.op    = rat_pkg::OP_SETST;
					cmd.code  = rat_pkg::ST_ZERO;
					state_d   = rat_pkg::S_EMIT;
				end else if (stat.c_zero) begin
					state_d = rat_pkg::S_OPSEL;
				end else begin
					state_d = rat_pkg::S_RG;
				end
			end
			// operand reduction
			rat_pkg::S_RG: begin
				multi = 1'b1; after = rat_pkg::S_RC; cmd.op = rat_pkg::OP_GCD;
				cmd.src_x = rat_pkg::R_C; cmd.src_y = rat_pkg::R_D; cmd.dst = rat_pkg::R_G;
			end
			rat_pkg::S_RC: begin
				multi = 1'b1; after = rat_pkg::S_RD; cmd.op = rat_pkg::OP_DIV;
				cmd.src_x = rat_pkg::R_C; cmd.src_y = rat_pkg::R_G; cmd.dst = rat_pkg::R_C;
			end
			rat_pkg::S_RD: begin
				multi = 1'b1; after = rat_pkg::S_OPSEL; cmd.op = rat_pkg::OP_DIV;
				cmd.src_x = rat_pkg::R_D; cmd.src_y = rat_pkg::R_G; cmd.dst = rat_pkg::R_D;
			end
			rat_pkg::S_OPSEL: begin
				case (stat.cmd)
					rat_pkg::CMD_LOAD: state_d = rat_pkg::S_LD;
					rat_pkg::CMD_ADD:  state_d = rat_pkg::S_AG;
					rat_pkg::CMD_SUB:  state_d = rat_pkg::S_AG;
					rat_pkg::CMD_MUL:  state_d = rat_pkg::S_MG1;
					rat_pkg::CMD_DIV: begin
						if (stat.c_zero) begin
							cmd.start = 1'b1;
							cmd.op    = rat_pkg::OP_SETST;
							cmd.code  = rat_pkg::ST_ZERO;
							state_d   = rat_pkg::S_EMIT;
						end else begin
							state_d = rat_pkg::S_MG1;
						end
					end
					default: state_d = rat_pkg::S_EMIT;
				endcase
			end
			rat_pkg::S_LD: begin
				cmd.start = 1'b1;
				cmd.op    = rat_pkg::OP_LOAD;
				state_d   = rat_pkg::S_FIN;
			end
			// add and subtract through the common multiple
			rat_pkg::S_AG: begin
				multi = 1'b1; after = rat_pkg::S_ABG; cmd.op = rat_pkg::OP_GCD;
				cmd.src_x = rat_pkg::R_B; cmd.src_y = rat_pkg::R_D; cmd.dst = rat_pkg::R_G;
			end
			rat_pkg::S_ABG: begin
				multi = 1'b1; after = rat_pkg::S_ADG; cmd.op = rat_pkg::OP_DIV;
				cmd.src_x = rat_pkg::R_B; cmd.src_y = rat_pkg::R_G; cmd.dst = rat_pkg::R_BG;
			end
			rat_pkg::S_ADG: begin
				multi = 1'b1; after = rat_pkg::S_AP; cmd.op = rat_pkg::OP_DIV;
				cmd.src_x = rat_pkg::R_D; cmd.src_y = rat_pkg::R_G; cmd.dst = rat_pkg::R_DG;
			end
			rat_pkg::S_AP: begin
				multi = 1'b1; after = rat_pkg::S_AQ; cmd.op = rat_pkg::OP_MUL;
				cmd.src_x = rat_pkg::R_A; cmd.src_y = rat_pkg::R_DG; cmd.dst = rat_pkg::R_P;
			end
			rat_pkg::S_AQ: begin
				multi = 1'b1; after = rat_pkg::S_AC; cmd.op = rat_pkg::OP_MUL;
				cmd.src_x = rat_pkg::R_C; cmd.src_y = rat_pkg::R_BG; cmd.dst = rat_pkg::R_Q;
			end
			rat_pkg::S_AC: begin
				cmd.start = 1'b1;
				cmd.op    = rat_pkg::OP_COMB;
				state_d   = rat_pkg::S_AZ;
			end
			rat_pkg::S_AZ: begin
				state_d = stat.num_zero ? rat_pkg::S_FIN : rat_pkg::S_AR;
			end
			rat_pkg::S_AR: begin
				multi = 1'b1; after = rat_pkg::S_AG2; cmd.op = rat_pkg::OP_MOD;
				cmd.src_y = rat_pkg::R_G; cmd.dst = rat_pkg::R_R;
			end
			rat_pkg::S_AG2: begin
				multi = 1'b1; after = rat_pkg::S_AN; cmd.op = rat_pkg::OP_GCD;
				cmd.src_x = rat_pkg::R_R; cmd.src_y = rat_pkg::R_G; cmd.dst = rat_pkg::R_G2;
			end
			rat_pkg::S_AN: begin
				multi = 1'b1; after = rat_pkg::S_AD; cmd.op = rat_pkg::OP_DIVW;
				cmd.src_y = rat_pkg::R_G2; cmd.dst = rat_pkg::R_NUM;
			end
			rat_pkg::S_AD: begin
				multi = 1'b1; after = rat_pkg::S_ADEN; cmd.op = rat_pkg::OP_DIV;
				cmd.src_x = rat_pkg::R_D; cmd.src_y = rat_pkg::R_G2; cmd.dst = rat_pkg::R_Y;
			end
			rat_pkg::S_ADEN: begin
				multi = 1'b1; after = rat_pkg::S_FIN; cmd.op = rat_pkg::OP_MUL;
				cmd.src_x = rat_pkg::R_BG; cmd.src_y = rat_pkg::R_Y; cmd.dst = rat_pkg::R_DEN;
			end
			// multiply and divide with cross cancellation
			rat_pkg::S_MG1: begin
				multi = 1'b1; after = rat_pkg::S_MG2; cmd.op = rat_pkg::OP_GCD;
				cmd.src_x = rat_pkg::R_A; cmd.src_y = u_reg; cmd.dst = rat_pkg::R_G1;
			end
			rat_pkg::S_MG2: begin
				multi = 1'b1; after = rat_pkg::S_MX; cmd.op = rat_pkg::OP_GCD;
				cmd.src_x = v_reg; cmd.src_y = rat_pkg::R_B; cmd.dst = rat_pkg::R_G2;
			end
			rat_pkg::S_MX: begin
				multi = 1'b1; after = rat_pkg::S_MY; cmd.op = rat_pkg::OP_DIV;
				cmd.src_x = rat_pkg::R_A; cmd.src_y = rat_pkg::R_G1; cmd.dst = rat_pkg::R_X;
			end
			rat_pkg::S_MY: begin
				multi = 1'b1; after = rat_pkg::S_MN; cmd.op = rat_pkg::OP_DIV;
				cmd.src_x = v_reg; cmd.src_y = rat_pkg::R_G2; cmd.dst = rat_pkg::R_Y;
			end
			rat_pkg::S_MN: begin
				multi = 1'b1; after = rat_pkg::S_MX2; cmd.op = rat_pkg::OP_MUL;
				cmd.src_x = rat_pkg::R_X; cmd.src_y = rat_pkg::R_Y; cmd.dst = rat_pkg::R_NUM;
				cmd.sr_xor = 1'b1;
			end
			rat_pkg::S_MX2: begin
				multi = 1'b1; after = rat_pkg::S_MY2; cmd.op = rat_pkg::OP_DIV;
				cmd.src_x = rat_pkg::R_B; cmd.src_y = rat_pkg::R_G2; cmd.dst = rat_pkg::R_X;
			end
			rat_pkg::S_MY2: begin
				multi = 1'b1; after = rat_pkg::S_MD; cmd.op = rat_pkg::OP_DIV;
				cmd.src_x = u_reg; cmd.src_y = rat_pkg::R_G1; cmd.dst = rat_pkg::R_Y;
			end
			rat_pkg::S_MD: begin
				multi = 1'b1; after = rat_pkg::S_FIN; cmd.op = rat_pkg::OP_MUL;
				cmd.src_x = rat_pkg::R_X; cmd.src_y = rat_pkg::R_Y; cmd.dst = rat_pkg::R_DEN;
			end
			rat_pkg::S_FIN: begin
				cmd.start = 1'b1;
				cmd.op    = rat_pkg::OP_FIN;
				state_d   = rat_pkg::S_EMIT;
			end
			rat_pkg::S_EMIT: begin
				cmd.op = rat_pkg::OP_EMIT;
				if (stat.out_free) begin
					cmd.start = 1'b1;
					state_d   = rat_pkg::S_IDLE;
				end
			end
			default: state_d = rat_pkg::S_IDLE;
		endcase

		// launch a unit once, then wait for its done
		if (multi) begin
			if (!issued_q) begin
				cmd.start = 1'b1;
				issued_d  = 1'b1;
			end else if (stat.done) begin
				issued_d = 1'b0;
				state_d  = after;
			end
		end
	end

endmodule

>>> hdl/rational_accumulator_alu_unit.sv
// Rational accumulator ALU, top level. Depends on rat_pkg, rat_ctrl, rat_dp.
// One item at a time; the next transfer is taken the cycle after the result is loaded.
// Bad command or zero denominator: the check state sets the status and goes straight to emit.
// A unit step launches the serial GCD, divider or multiplier and waits for its done before the
// next step starts. A zero operand skips the operand reduction steps.
// Reset (arst_n low, asynchronous) sets the accumulator to 0/1 and empties the output.
`timescale 1ns / 1ps

module rational_accumulator_alu_unit #(
	parameter int WIDTH = 32
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  rat_pkg::in_t  in_data,
	output logic          out_valid,
	input  logic          out_ready,
	output rat_pkg::out_t out_data
);
	rat_pkg::dp_cmd_t  dp_cmd;
	rat_pkg::dp_stat_t dp_stat;

	rat_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.stat(dp_stat), .cmd(dp_cmd)
	);

	rat_dp #(.WIDTH(WIDTH)) u_dp (
		.clk(clk), .arst_n(arst_n), .in_data(in_data), .cmd(dp_cmd), .stat(dp_stat),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
	);

	// one item in flight: no transfer right after a transfer
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("input taken while an item is in work");

	// emitted status is a defined code
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.status == rat_pkg::ST_OK
			|| out_data.status == rat_pkg::ST_ZERO || out_data.status == rat_pkg::ST_OVF))
		else $error("undefined status code");

	// units only finish while an item is in work
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		dp_stat.done |-> !in_ready)
		else $error("unit done while idle");

endmodule
